// ===== rtl/bgpr_pkg.sv =====
package bgpr_pkg;

  localparam int COORD_W = 9;
  localparam int ROW_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int PCT_W   = 7;
  localparam int H5_W    = 7;
  // Signed working width for box-relative coordinates and bounds.
  localparam int SW      = COORD_W + 2;

  localparam int DISPLAY_WIDTH_DEF  = 296;
  localparam int DISPLAY_HEIGHT_DEF = 128;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_BOX_LEFT       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOX_TOP        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOX_WIDTH      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOX_HEIGHT     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CAP_LEFT       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CHARGE_PERCENT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SHOWN          = 3'd6;

  localparam logic [COORD_W-1:0] BOX_LEFT_RST   = 9'd275;
  localparam logic [COORD_W-1:0] BOX_TOP_RST    = 9'd1;
  localparam logic [COORD_W-1:0] BOX_WIDTH_RST  = 9'd20;
  localparam logic [COORD_W-1:0] BOX_HEIGHT_RST = 9'd10;
  localparam logic [PCT_W-1:0]   PCT_RST        = 7'd50;

  localparam logic [PCT_W-1:0]   PCT_MAX     = 7'd100;
  localparam logic [COORD_W-1:0] FILL_MARGIN = 9'd5;

  // floor(v/100) = (v*83887) >> 23 for every v below 91180.
  localparam int                 PROD_W       = COORD_W + PCT_W;
  localparam logic [16:0]        DIV100_MUL   = 17'd83887;
  localparam int                 DIV100_SHIFT = 23;
  // floor(v/5) = (v*205) >> 10 for every v below 1024.
  localparam logic [7:0]         DIV5_MUL     = 8'd205;
  localparam int                 DIV5_SHIFT   = 10;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic               cap_left;
    logic               shown;
    logic [H5_W-1:0]    h5;
    logic [COORD_W-1:0] fill;
  } gauge_cfg_t;

endpackage

// ===== rtl/bgpr_regs.sv =====
module bgpr_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bgpr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [bgpr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [bgpr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output bgpr_pkg::gauge_cfg_t             cfg
);
  import bgpr_pkg::*;

  logic [COORD_W-1:0]   left_r, top_r, width_r, height_r;
  logic                 cap_left_r, shown_r;
  logic [PCT_W-1:0]     pct_r, pct_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;
  logic [COORD_W-1:0]   span;
  logic [PROD_W-1:0]    prod_r;
  logic [PROD_W+16:0]   fill_full;
  logic [COORD_W-1:0]   fill_r;
  logic [COORD_W+7:0]   h5_full;
  logic [H5_W-1:0]      h5_r;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  assign pct_nxt = (pwdata[PCT_W-1:0] > PCT_MAX) ? PCT_MAX : pwdata[PCT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r     <= BOX_LEFT_RST;
      top_r      <= BOX_TOP_RST;
      width_r    <= BOX_WIDTH_RST;
      height_r   <= BOX_HEIGHT_RST;
      cap_left_r <= 1'b1;
      pct_r      <= PCT_RST;
      shown_r    <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_BOX_LEFT:       left_r     <= pwdata[COORD_W-1:0];
        REG_BOX_TOP:        top_r      <= pwdata[COORD_W-1:0];
        REG_BOX_WIDTH:      width_r    <= pwdata[COORD_W-1:0];
        REG_BOX_HEIGHT:     height_r   <= pwdata[COORD_W-1:0];
        REG_CAP_LEFT:       cap_left_r <= pwdata[0];
        REG_CHARGE_PERCENT: pct_r      <= pct_nxt;
        REG_SHOWN:          shown_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Fill length and cap inset follow the registers with a short lag,
  // which runs out before an item started after a write reaches them.
  assign span      = (width_r >= FILL_MARGIN) ? (width_r - FILL_MARGIN) : '0;
  assign fill_full = (PROD_W+17)'(prod_r) * (PROD_W+17)'(DIV100_MUL);
  assign h5_full   = (COORD_W+8)'(height_r) * (COORD_W+8)'(DIV5_MUL);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(pct_r) * PROD_W'(span);
    fill_r <= fill_full[DIV100_SHIFT +: COORD_W];
    h5_r   <= h5_full[DIV5_SHIFT +: H5_W];
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_BOX_LEFT:       prdata = CFG_DATA_W'(left_r);
      REG_BOX_TOP:        prdata = CFG_DATA_W'(top_r);
      REG_BOX_WIDTH:      prdata = CFG_DATA_W'(width_r);
      REG_BOX_HEIGHT:     prdata = CFG_DATA_W'(height_r);
      REG_CAP_LEFT:       prdata = CFG_DATA_W'(cap_left_r);
      REG_CHARGE_PERCENT: prdata = CFG_DATA_W'(pct_r);
      REG_SHOWN:          prdata = CFG_DATA_W'(shown_r);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    cfg.left     = left_r;
    cfg.top      = top_r;
    cfg.width    = width_r;
    cfg.height   = height_r;
    cfg.cap_left = cap_left_r;
    cfg.shown    = shown_r;
    cfg.h5       = h5_r;
    cfg.fill     = fill_r;
  end

endmodule

// ===== rtl/bgpr_raster.sv =====
module bgpr_raster #(
  parameter int DISPLAY_WIDTH  = bgpr_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = bgpr_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bgpr_pkg::gauge_cfg_t          cfg,
  input  logic                          item_valid,
  input  logic [bgpr_pkg::COORD_W-1:0]  column,
  input  logic [bgpr_pkg::ROW_W-1:0]    byte_row,
  output logic                          pix_valid,
  output logic [bgpr_pkg::BYTE_W-1:0]   pix_byte
);
  import bgpr_pkg::*;

  localparam logic signed [SW-1:0] DW_S = SW'(DISPLAY_WIDTH);
  localparam logic signed [SW-1:0] DH_S = SW'(DISPLAY_HEIGHT);

  // Stage 1: captured item.
  logic               v1_r;
  logic [COORD_W-1:0] x1_r;
  logic [ROW_W-1:0]   row1_r;

  // Stage 2: column decoded against the box.
  logic                 v2_r;
  logic                 col_in_r, col_in_nxt;
  logic signed [SW-1:0] bx_r, bx_nxt;
  logic [ROW_W-1:0]     row2_r;

  logic                 v3_r;
  logic [BYTE_W-1:0]    byte_r, byte_nxt;

  logic signed [SW-1:0] x_s, l_s, t_s, w_s, h_s, h5_s, fill_s;

  assign l_s    = SW'(cfg.left);
  assign t_s    = SW'(cfg.top);
  assign w_s    = SW'(cfg.width);
  assign h_s    = SW'(cfg.height);
  assign h5_s   = SW'(cfg.h5);
  assign fill_s = SW'(cfg.fill);
  assign x_s    = SW'(x1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= item_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      x1_r   <= column;
      row1_r <= byte_row;
    end
    col_in_r <= col_in_nxt;
    bx_r     <= bx_nxt;
    row2_r   <= row1_r;
    byte_r   <= byte_nxt;
  end

  assign col_in_nxt = cfg.shown && (x_s < DW_S) && (x_s >= l_s) && (x_s < l_s + w_s);
  assign bx_nxt     = x_s - l_s;

  function automatic logic pixel_on(input logic signed [SW-1:0] bx,
                                    input logic signed [SW-1:0] by);
    logic cap_rows;
    logic on;
    cap_rows = (by >= h5_s) && (by < h_s - h5_s);
    if (cfg.cap_left) begin
      on = (bx == 0 && cap_rows)
        || (by == 0 && bx > 0)
        || (bx == 1 && by > 0)
        || (by == h_s - 1 && bx > 0)
        || (bx == w_s - 1 && by > 0)
        || (bx >= w_s - fill_s - 2 && bx < w_s - 2 && by > 1 && by < h_s - 2);
    end else begin
      on = (bx == w_s - 1 && cap_rows)
        || (bx == w_s - 2 && by > 0)
        || (bx == 0 && by > 0)
        || (by == 0 && bx < w_s - 1)
        || (by == h_s - 1 && bx < w_s - 1)
        || (bx > 1 && bx <= fill_s + 1 && by > 1 && by < h_s - 2);
    end
    return on;
  endfunction

  // Eight rows of the group are judged side by side; the top row lands in bit 7.
  always_comb begin
    logic signed [SW-1:0] y_s;
    byte_nxt = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      y_s = SW'({row2_r, 3'b000}) + SW'(k);
      byte_nxt[BYTE_W-1-k] = col_in_r && (y_s < DH_S) && (y_s >= t_s)
                             && (y_s < t_s + h_s) && pixel_on(bx_r, y_s - t_s);
    end
  end

  assign pix_valid = v3_r;
  assign pix_byte  = byte_r;

endmodule

// ===== rtl/battery_gauge_pixel_raster_unit.sv =====
// Battery-gauge raster unit.
// Input: pulse start with in_column and in_byte_row; the item is taken at
// any rising edge where start is high and busy is low. busy is always low,
// so one item can be taken every cycle.
// Output: out_strobe is high for one cycle with out_pixel_byte, eight
// vertically adjacent pixels of that column, top row in bit 7.
// Pipeline: the item passes the input register, the column decode register
// and the result register in turn before it is shown. Throughput is
// one item per cycle; results leave in the order the items came in.
// The receiver cannot stall; each result is valid for its single cycle only.
// Configuration: APB-style port, register i at byte address 4*i, pready
// always high. Writes are meant for idle periods; items started after the
// write completes see the new setting.
// Reset (rst_n low, synchronous) loads the default gauge geometry and empties
// the pipeline; no strobe follows until new items arrive.
module battery_gauge_pixel_raster_unit #(
  parameter int DISPLAY_WIDTH  = bgpr_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = bgpr_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [bgpr_pkg::COORD_W-1:0]     in_column,
  input  logic [bgpr_pkg::ROW_W-1:0]       in_byte_row,
  output logic                             out_strobe,
  output logic [bgpr_pkg::BYTE_W-1:0]      out_pixel_byte,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bgpr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [bgpr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [bgpr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import bgpr_pkg::*;

  gauge_cfg_t cfg;
  logic       accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  bgpr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bgpr_raster #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_raster (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (accept),
    .column     (in_column),
    .byte_row   (in_byte_row),
    .pix_valid  (out_strobe),
    .pix_byte   (out_pixel_byte)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bgpr_pkg::*;

  localparam int DISP_W      = DISPLAY_WIDTH_DEF;
  localparam int DISP_H      = DISPLAY_HEIGHT_DEF;
  localparam int NUM_REGS    = REG_SHOWN + 1;
  localparam int RAND_ITEMS  = 600;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  // Index past the last register; writes there must change nothing.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

  class raster_scoreboard;
    logic [COORD_W-1:0] left, top, width, height;
    logic               cap_left, shown;
    logic [PCT_W-1:0]   pct;
    logic [BYTE_W-1:0]  pending_bytes[$];
    int                 errors;

    function new();
      left     = BOX_LEFT_RST;
      top      = BOX_TOP_RST;
      width    = BOX_WIDTH_RST;
      height   = BOX_HEIGHT_RST;
      cap_left = 1'b1;
      pct      = PCT_RST;
      shown    = 1'b1;
      errors   = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BOX_LEFT:       left = data[COORD_W-1:0];
        REG_BOX_TOP:        top = data[COORD_W-1:0];
        REG_BOX_WIDTH:      width = data[COORD_W-1:0];
        REG_BOX_HEIGHT:     height = data[COORD_W-1:0];
        REG_CAP_LEFT:       cap_left = data[0];
        REG_CHARGE_PERCENT: pct = (data[PCT_W-1:0] > PCT_MAX) ? PCT_MAX : data[PCT_W-1:0];
        REG_SHOWN:          shown = data[0];
        default: ;
      endcase
    endfunction

    function logic [CFG_DATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
        REG_BOX_LEFT:       return 32'(left);
        REG_BOX_TOP:        return 32'(top);
        REG_BOX_WIDTH:      return 32'(width);
        REG_BOX_HEIGHT:     return 32'(height);
        REG_CAP_LEFT:       return 32'(cap_left);
        REG_CHARGE_PERCENT: return 32'(pct);
        REG_SHOWN:          return 32'(shown);
        default:            return '0;
      endcase
    endfunction

    // All bounds are worked out on signed ints so that narrow boxes never wrap.
    function bit pixel_on(int x, int y);
      int l, t, w, h, bx, by, h5, fill;
      bit cap_rows;
      l = int'(left);
      t = int'(top);
      w = int'(width);
      h = int'(height);
      if (!shown) return 1'b0;
      if (x >= DISP_W || y >= DISP_H) return 1'b0;
      if (x < l || y < t || x >= l + w || y >= t + h) return 1'b0;
      bx = x - l;
      by = y - t;
      h5 = h / 5;
      fill = (w >= 5) ? (int'(pct) * (w - 5)) / 100 : 0;
      cap_rows = (by >= h5) && (by < h - h5);
      if (cap_left) begin
        return (bx == 0 && cap_rows) || (by == 0 && bx > 0) || (bx == 1 && by > 0)
            || (by == h - 1 && bx > 0) || (bx == w - 1 && by > 0)
            || (bx >= w - fill - 2 && bx < w - 2 && by > 1 && by < h - 2);
      end else begin
        return (bx == w - 1 && cap_rows) || (bx == w - 2 && by > 0) || (bx == 0 && by > 0)
            || (by == 0 && bx < w - 1) || (by == h - 1 && bx < w - 1)
            || (bx > 1 && bx <= fill + 1 && by > 1 && by < h - 2);
      end
    endfunction

    function logic [BYTE_W-1:0] raster_byte(logic [COORD_W-1:0] col, logic [ROW_W-1:0] row);
      logic [BYTE_W-1:0] b;
      b = '0;
      for (int k = 0; k < BYTE_W; k++) begin
        if (pixel_on(int'(col), int'(row) * 8 + k)) b[BYTE_W-1-k] = 1'b1;
      end
      return b;
    endfunction

    function void note_item(logic [COORD_W-1:0] col, logic [ROW_W-1:0] row);
      pending_bytes.push_back(raster_byte(col, row));
    endfunction

    function void check_byte(logic [BYTE_W-1:0] got);
      logic [BYTE_W-1:0] want;
      if (pending_bytes.size() == 0) begin
        $error("pixel_byte: result with no item outstanding, actual %02h", got);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (got !== want) begin
        $error("pixel_byte mismatch: expected %02h, actual %02h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic [COORD_W-1:0]    in_column = '0;
  logic [ROW_W-1:0]      in_byte_row = '0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic                  busy;
  logic                  out_strobe;
  logic [BYTE_W-1:0]     out_pixel_byte;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    cycle_count = 0;

  string reg_names[NUM_REGS] = '{"box_left", "box_top", "box_width", "box_height",
                                 "cap_left", "charge_percent", "shown"};

  raster_scoreboard sb = new();

  battery_gauge_pixel_raster_unit #(
    .DISPLAY_WIDTH (DISP_W),
    .DISPLAY_HEIGHT(DISP_H)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_column     (in_column),
    .in_byte_row   (in_byte_row),
    .out_strobe    (out_strobe),
    .out_pixel_byte(out_pixel_byte),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Results are checked before the item taken at the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_byte(out_pixel_byte);
      if (start && !busy) sb.note_item(in_column, in_byte_row);
    end
  end

  task automatic send_item(input logic [COORD_W-1:0] col, input logic [ROW_W-1:0] row,
                           input int gap);
    start <= 1'b1;
    in_column <= col;
    in_byte_row <= row;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The item taken at the last edge is only noted at that same edge, so the
  // queue is first looked at on the following edge.
  task automatic finish_phase();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_bytes.size() != 0);
  endtask

  task automatic cfg_access(input logic [REG_IDX_W-1:0] idx, input bit is_write,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (is_write) sb.write_reg(idx, wdata);
  endtask

  task automatic program_gauge(input int l, input int t, input int w, input int h,
                               input int cap, input int pct, input int shw);
    logic [CFG_DATA_W-1:0] vals[NUM_REGS];
    logic [CFG_DATA_W-1:0] data, rd;
    logic [REG_IDX_W-1:0]  idx;
    int                    shift;
    vals = '{l, t, w, h, cap, pct, shw};
    for (idx = REG_BOX_LEFT; idx <= REG_SHOWN; idx++) begin
      shift = (idx == REG_CHARGE_PERCENT) ? PCT_W :
              (idx == REG_CAP_LEFT || idx == REG_SHOWN) ? 1 : COORD_W;
      data = vals[idx];
      // Bits above the field must be dropped by the register.
      if ($urandom_range(0, 3) == 0) data = data | ($urandom << shift);
      cfg_access(idx, 1'b1, data, rd);
    end
    if ($urandom_range(0, 2) == 0) cfg_access(REG_SPARE, 1'b1, $urandom, rd);
    for (idx = REG_BOX_LEFT; idx <= REG_SHOWN; idx++) begin
      cfg_access(idx, 1'b0, '0, rd);
      if (rd !== sb.reg_value(idx)) begin
        $error("%s readback mismatch: expected %0d, actual %0d",
               reg_names[idx], sb.reg_value(idx), rd);
        sb.errors++;
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic int rand_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return $urandom_range(0, 5);
    if (r < 17) return $urandom_range(400, 511);
    if (r < 20) return 511;
    return $urandom_range(6, 40);
  endfunction

  function automatic int rand_origin(int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 511);
    if (r < 15) return 0;
    return $urandom_range(0, span);
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int probe_cols[9];
    int l, t, w, h, cap, pct, shw;
    int phase, sent, n, col, y;
    bit burst;

    probe_cols = '{0, 274, 275, 276, 277, 285, 293, 294, 295};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default gauge: walk the cap, outline, fill and the box edges.
    foreach (probe_cols[i]) begin
      for (int r = 0; r < 2; r++) send_item(COORD_W'(probe_cols[i]), ROW_W'(r), 0);
    end
    send_item(9'd511, 6'd63, 0);
    finish_phase();

    // Box hanging over the panel's right and bottom edges, with an
    // over-range charge level that has to saturate.
    program_gauge(290, 120, 12, 12, 0, 127, 1);
    send_item(9'd290, 6'd15, 0);
    send_item(9'd296, 6'd15, 1);
    send_item(9'd301, 6'd15, 0);
    send_item(9'd295, 6'd16, 0);
    finish_phase();

    // Box too narrow for any fill and too short for a trimmed cap.
    program_gauge(10, 9, 3, 3, 1, 37, 1);
    send_item(9'd10, 6'd1, 0);
    send_item(9'd12, 6'd1, 2);
    finish_phase();

    phase = 0;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      case (phase)
        0: begin l = 0; t = 0; w = 511; h = 511; cap = 1; pct = 100; shw = 1; end
        1: begin l = 511; t = 511; w = 6; h = 5; cap = 0; pct = 0; shw = 1; end
        2: begin l = 275; t = 1; w = 20; h = 10; cap = 0; pct = 64; shw = 0; end
        3: begin l = 100; t = 40; w = 0; h = 0; cap = 0; pct = 100; shw = 1; end
        default: begin
          w = rand_span();
          h = rand_span();
          l = rand_origin(DISP_W + 4);
          t = rand_origin(DISP_H + 4);
          cap = $urandom_range(0, 1);
          case ($urandom_range(0, 6))
            0: pct = 0;
            1: pct = 100;
            2: pct = $urandom_range(101, 127);
            default: pct = $urandom_range(0, 100);
          endcase
          shw = ($urandom_range(0, 9) != 0);
        end
      endcase
      program_gauge(l, t, w, h, cap, pct, shw);

      n = $urandom_range(20, 60);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
        // Most items land on or just around the box; the rest roam the
        // whole input range.
        if ($urandom_range(0, 3) == 0) begin
          col = $urandom_range(0, 511);
          y = 8 * $urandom_range(0, 63);
        end else begin
          col = l - 2 + int'($urandom_range(0, w + 3));
          y = t - 8 + int'($urandom_range(0, h + 16));
          if (y < 0) y = 0;
        end
        send_item(COORD_W'(col), ROW_W'(y / 8), burst ? 0 : rand_gap());
        sent++;
      end
      finish_phase();
      phase++;
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bgpr_pkg.sv
rtl/bgpr_regs.sv
rtl/bgpr_raster.sv
rtl/battery_gauge_pixel_raster_unit.sv
tb/sv/tb_top.sv
